>>> hdl/tkz_pkg.sv
// shared types, codes and constants of the csv/tsv field tokenizer
`timescale 1ns / 1ps

package tkz_pkg;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [11:0] CAP_RESET   = 12'd4095;
    localparam int          CFG_ADDR_W  = 3;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;
    localparam logic [1:0] KIND_TEXT  = 2'd3;

    // register indexes (byte address is 4 * index)
    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    typedef enum logic [5:0] {
        MODE_START  = 6'b000001,
        MODE_PLAIN  = 6'b000010,
        MODE_QUOTED = 6'b000100,
        MODE_QSEEN  = 6'b001000,
        MODE_AFTER  = 6'b010000,
        MODE_CR     = 6'b100000
    } t_mode;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] column_number;
        logic [15:0] row_number;
        logic [11:0] field_length;
        logic        truncated;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  separator;
        logic [11:0] field_capacity;
    } t_cfg;

endpackage

>>> hdl/tkz_apb_regs.sv
// configuration registers behind an apb-style port
`timescale 1ns / 1ps

module tkz_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tkz_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tkz_pkg::t_cfg                  o_cfg
);
    import tkz_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_SEPARATOR: n_cfg.separator      = pwdata[7:0];
                REG_CAPACITY:  n_cfg.field_capacity = pwdata[11:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEPARATOR: prdata = {24'd0, r_cfg.separator};
            REG_CAPACITY:  prdata = {20'd0, r_cfg.field_capacity};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator      <= CH_TAB;
            r_cfg.field_capacity <= CAP_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hdl/tkz_core.sv
// parse state and single-pass next-state / result logic
`timescale 1ns / 1ps

module tkz_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkz_pkg::t_cfg       i_cfg,
    input  tkz_pkg::t_in_item   i_item,
    input  logic                i_fire,
    output logic                o_res_valid,
    output tkz_pkg::t_out_item  o_res
);
    import tkz_pkg::*;

    t_mode       r_mode,  n_mode;
    logic [11:0] r_len,   n_len;
    logic [15:0] r_col,   n_col;
    logic [15:0] r_row,   n_row;
    logic        r_ovf,   n_ovf;

    t_mode       eff_mode;
    logic [7:0]  b;
    logic        is_sep;
    logic        is_eol;
    logic        term_hit;
    logic        do_term;
    logic        do_keep;

    assign b        = i_item.data_byte;
    assign is_sep   = (b == i_cfg.separator);
    assign is_eol   = (b == CH_CR) || (b == CH_LF);
    assign term_hit = is_sep || is_eol;
    assign eff_mode = (r_mode == MODE_CR) ? MODE_START : r_mode;

    always_comb begin
        n_mode  = r_mode;
        n_len   = r_len;
        n_col   = r_col;
        n_row   = r_row;
        n_ovf   = r_ovf;
        do_term = 1'b0;
        do_keep = 1'b0;

        o_res_valid         = 1'b0;
        o_res.kind          = KIND_DATA;
        o_res.out_byte      = 8'd0;
        o_res.column_number = r_col;
        o_res.row_number    = r_row;
        o_res.field_length  = r_len;
        o_res.truncated     = r_ovf;

        priority if (i_item.op == OP_END) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_TEXT;
            n_mode      = MODE_START;
            n_len       = 12'd0;
            n_col       = 16'd0;
            n_row       = 16'd0;
            n_ovf       = 1'b0;
        end else if (r_mode == MODE_CR && b == CH_LF) begin
            // lf right after a cr row end is swallowed
            n_mode = MODE_START;
        end else begin
            unique case (eff_mode)
                MODE_PLAIN: begin
                    do_term = term_hit;
                    do_keep = !term_hit;
                end
                MODE_QUOTED: begin
                    if (b == CH_QUOTE) n_mode = MODE_QSEEN;
                    else               do_keep = 1'b1;
                end
                MODE_QSEEN, MODE_AFTER: begin
                    priority if (eff_mode == MODE_QSEEN && b == CH_QUOTE) begin
                        n_mode  = MODE_QUOTED;
                        do_keep = 1'b1;
                    end else if (term_hit) begin
                        do_term = 1'b1;
                    end else begin
                        n_mode = MODE_AFTER;
                    end
                end
                default: begin
                    priority if (b == CH_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else if (term_hit) begin
                        do_term = 1'b1;
                    end else begin
                        n_mode  = MODE_PLAIN;
                        do_keep = 1'b1;
                    end
                end
            endcase

            if (do_term) begin
                o_res_valid = 1'b1;
                n_len       = 12'd0;
                n_ovf       = 1'b0;
                if (is_sep) begin
                    // separator test wins over cr/lf
                    o_res.kind = KIND_FIELD;
                    n_mode     = MODE_START;
                    if (r_col != COUNT_MAX) n_col = r_col + 16'd1;
                end else begin
                    o_res.kind = KIND_ROW;
                    n_col      = 16'd0;
                    n_mode     = (b == CH_CR) ? MODE_CR : MODE_START;
                    if (r_row != COUNT_MAX) n_row = r_row + 16'd1;
                end
            end

            if (do_keep) begin
                if (r_len < i_cfg.field_capacity) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_DATA;
                    o_res.out_byte     = b;
                    n_len              = r_len + 12'd1;
                    o_res.field_length = n_len;
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_len  <= 12'd0;
            r_col  <= 16'd0;
            r_row  <= 16'd0;
            r_ovf  <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_col  <= n_col;
            r_row  <= n_row;
            r_ovf  <= n_ovf;
        end
    end

endmodule

>>> hdl/csv_tsv_field_tokenizer_top.sv
// top level of the csv/tsv field tokenizer: request/result registers and config port
`timescale 1ns / 1ps

//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------
//  request  | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  result   | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//  config   | in        | psel / penable / pready    | paddr, pwdata, prdata
//
//  one request per cycle sustained while the result channel is not stalled; a request
//  is held in the request register, the parse logic resolves it there, and its
//  result (if any) is shown from the result register
//  reset is synchronous, active low; it clears the parse state, both valid
//  flags and sets separator to tab and field capacity to 4095
//  a stalled result holds the request register only when that request makes
//  a result; requests that make no result drain even while output is stalled

module csv_tsv_field_tokenizer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tkz_pkg::t_in_item              i_in_item,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tkz_pkg::t_out_item             o_out_item,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tkz_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tkz_pkg::*;

    t_cfg      cfg;

    // request register
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_item;

    // result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    // parse logic outputs
    logic      res_valid;
    t_out_item res;

    logic      advance;
    logic      accept;
    logic      out_free;

    tkz_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tkz_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (r_in_item),
        .i_fire      (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result slot can take a new value if empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // a held request moves on unless it makes a result and the result slot is blocked
    assign advance    = r_in_valid && (!res_valid || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept)       n_in_valid = 1'b1;
        else if (advance) n_in_valid = 1'b0;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance && res_valid) n_out_valid = 1'b1;
        else if (!i_out_stall)    n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
        if (advance && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a result never lands on a stalled, still-full result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(advance && res_valid && r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // a kept data byte always counts itself in the field length
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.kind == KIND_DATA) |-> (res.field_length != 12'd0))
        else $error("data result with zero field length");

    // an accepted request sits in the request register next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("accepted request lost");

    // text end always reports from the request register as a result
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_item.op == OP_END) |-> res_valid)
        else $error("end of text gave no result");

endmodule
